FILE: hw/rtl/tmgr_pkg.sv
// tmgr_pkg: shared types, constants, font table and character mapping
// for the text-mode glyph renderer. No dependencies.
package tmgr_pkg;

    // Screen and text grid geometry
    localparam int unsigned SCREEN_WIDTH  = 128;
    localparam int unsigned SCREEN_HEIGHT = 64;
    localparam int unsigned TEXT_COLUMNS  = 16;
    localparam int unsigned TEXT_LINES    = 4;
    localparam int unsigned CELL_H        = 14;
    localparam int unsigned ORIGIN_Y      = 5;

    // Framebuffer organization
    localparam int unsigned STORE_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
    localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
    localparam int unsigned X_W         = $clog2(SCREEN_WIDTH);
    localparam int unsigned PAGE_W      = $clog2(SCREEN_HEIGHT / 8);

    // Glyph footprint: 3x5 dots, each a 2x2 block -> 6 byte columns, up to 3 pages
    localparam int unsigned GLYPH_ROWS  = 5;
    localparam int unsigned DOT_ROWS    = 2 * GLYPH_ROWS;
    localparam int unsigned BYTE_COLS   = 6;
    localparam int unsigned PAGE_SPAN   = 3;
    localparam int unsigned GLYPH_BITS  = 3 * GLYPH_ROWS;

    // Font indexes
    localparam logic [5:0] DIGIT_BASE  = 6'd26;
    localparam logic [5:0] BLANK_GLYPH = 6'd36;

    // Function codes
    localparam logic [1:0] FN_CLEAR = 2'd0;
    localparam logic [1:0] FN_PUT   = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    // Character codes with special handling
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Request to the glyph mask unit
    typedef struct packed {
        logic [GLYPH_BITS-1:0] glyph;     // row 0 in the top three bits
        logic [1:0]            dot_col;   // glyph column 0..2
        logic [2:0]            y_off;     // glyph origin row within its page
        logic [1:0]            page_sel;  // page 0..2 relative to origin page
    } t_mask_req;

    // Framebuffer write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    // Font table: one octal digit per glyph row, top row first, MSB = left dot
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [5:0] idx);
        logic [GLYPH_BITS-1:0] g;
        unique case (idx)
            6'd0:  g = 15'o25755;  6'd1:  g = 15'o65656;
            6'd2:  g = 15'o34443;  6'd3:  g = 15'o65556;
            6'd4:  g = 15'o74647;  6'd5:  g = 15'o74644;
            6'd6:  g = 15'o34553;  6'd7:  g = 15'o55755;
            6'd8:  g = 15'o72227;  6'd9:  g = 15'o11152;
            6'd10: g = 15'o56465;  6'd11: g = 15'o44447;
            6'd12: g = 15'o57755;  6'd13: g = 15'o65555;
            6'd14: g = 15'o25552;  6'd15: g = 15'o65644;
            6'd16: g = 15'o25521;  6'd17: g = 15'o65665;
            6'd18: g = 15'o34216;  6'd19: g = 15'o72222;
            6'd20: g = 15'o55557;  6'd21: g = 15'o55552;
            6'd22: g = 15'o55775;  6'd23: g = 15'o55255;
            6'd24: g = 15'o55222;  6'd25: g = 15'o71247;
            6'd26: g = 15'o75557;  6'd27: g = 15'o26227;
            6'd28: g = 15'o61247;  6'd29: g = 15'o61216;
            6'd30: g = 15'o55711;  6'd31: g = 15'o74616;
            6'd32: g = 15'o34652;  6'd33: g = 15'o71222;
            6'd34: g = 15'o75757;  6'd35: g = 15'o25316;
            6'd37: g = 15'o00002;  6'd38: g = 15'o00024;
            6'd39: g = 15'o22202;  6'd40: g = 15'o61202;
            6'd41: g = 15'o22000;  6'd42: g = 15'o00700;
            6'd43: g = 15'o02020;
            default: g = '0;
        endcase
        return g;
    endfunction

    // Character byte to font index; lowercase folds to uppercase
    function automatic logic [5:0] map_glyph(input logic [7:0] ch);
        logic [7:0] c;
        logic [5:0] idx;
        c = ch;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'd32;
        end
        priority if (c >= 8'h41 && c <= 8'h5A) begin
            idx = 6'(c - 8'h41);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            idx = DIGIT_BASE + 6'(c - 8'h30);
        end else if (c == 8'h2E) begin
            idx = 6'd37;
        end else if (c == 8'h2C) begin
            idx = 6'd38;
        end else if (c == 8'h21) begin
            idx = 6'd39;
        end else if (c == 8'h3F) begin
            idx = 6'd40;
        end else if (c == 8'h27) begin
            idx = 6'd41;
        end else if (c == 8'h2D) begin
            idx = 6'd42;
        end else if (c == 8'h3A) begin
            idx = 6'd43;
        end else begin
            idx = BLANK_GLYPH;
        end
        return idx;
    endfunction

endpackage

FILE: hw/rtl/tmgr_in_if.sv
// tmgr_in_if: command channel of the glyph renderer (valid/ready + command item).
// No dependencies.
interface tmgr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] char_code;
    logic [9:0] read_address;

    modport source (output valid, func, char_code, read_address, input ready);
    modport sink   (input valid, func, char_code, read_address, output ready);
endinterface

FILE: hw/rtl/tmgr_out_if.sv
// tmgr_out_if: result channel of the glyph renderer (valid/ready + result item).
// No dependencies.
interface tmgr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       accepted;
    logic [3:0] cursor_column;
    logic [2:0] cursor_line;

    modport source (output valid, read_data, accepted, cursor_column, cursor_line,
                    input ready);
    modport sink   (input valid, read_data, accepted, cursor_column, cursor_line,
                    output ready);
endinterface

FILE: hw/rtl/tmgr_glyph_mask.sv
// tmgr_glyph_mask: shared shift unit; builds the OR mask of one framebuffer byte
// (one pixel column, one page) of a doubled 3x5 glyph. Depends on tmgr_pkg.
module tmgr_glyph_mask (
    input  tmgr_pkg::t_mask_req i_req,
    output logic [7:0]          o_mask
);

    logic [tmgr_pkg::DOT_ROWS-1:0] strip;
    logic [23:0]                   window;

    // Vertical strip: each glyph row covers two pixel rows
    always_comb begin
        for (int r = 0; r < tmgr_pkg::DOT_ROWS; r++) begin
            logic [2:0] row_val;
            row_val = i_req.glyph[(tmgr_pkg::GLYPH_BITS - 3) - 3 * (r / 2) +: 3];
            unique case (i_req.dot_col)
                2'd0:    strip[r] = row_val[2];
                2'd1:    strip[r] = row_val[1];
                default: strip[r] = row_val[0];
            endcase
        end
    end

    // Align strip to its page offset, then pick the requested page byte
    assign window = {{(24 - tmgr_pkg::DOT_ROWS){1'b0}}, strip} << i_req.y_off;

    always_comb begin
        unique case (i_req.page_sel)
            2'd0:    o_mask = window[7:0];
            2'd1:    o_mask = window[15:8];
            default: o_mask = window[23:16];
        endcase
    end

endmodule

FILE: hw/rtl/tmgr_frame_mem.sv
// tmgr_frame_mem: 1024-byte framebuffer, one write and one registered read a cycle.
// Depends on tmgr_pkg.
module tmgr_frame_mem (
    input  logic                        i_clk,
    input  tmgr_pkg::t_mem_wr           i_wr,
    input  logic                        i_rd_en,
    input  logic [tmgr_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                  o_rd_data
);

    logic [7:0] r_mem [tmgr_pkg::STORE_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/text_mode_glyph_renderer.sv
// text_mode_glyph_renderer: top level; sequencer that clears, reads and draws
// characters into the page-ordered framebuffer. Depends on tmgr_pkg, tmgr_in_if,
// tmgr_out_if, tmgr_glyph_mask and tmgr_frame_mem.
//
//  channel   dir   handshake        item
//  i_cmd     in    valid / ready    func, char_code, read_address
//  o_res     out   valid / ready    read_data, accepted, cursor_column, cursor_line
//
// A drawn character makes 18 byte read-modify-writes through the framebuffer,
// pipelined one per cycle, then drains the last write and returns the result.
// A read passes ST_RD and ST_RD_WAIT; a skipped put or unused code goes
// straight to the result. Clear writes each framebuffer byte, one per cycle.
// After reset the same clearing pass runs with i_cmd.ready low.
// One item is in flight at a time; i_cmd.ready stays low until o_res is taken.
module text_mode_glyph_renderer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tmgr_in_if.sink         i_cmd,
    tmgr_out_if.source      o_res
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_RD,
        ST_RD_WAIT,
        ST_RESP
    } t_state;

    t_state                       r_state;
    logic [tmgr_pkg::ADDR_W-1:0]  r_clr_addr;
    logic                         r_clr_reply;
    logic [3:0]                   r_col;
    logic [2:0]                   r_line;

    // Draw job
    logic [tmgr_pkg::GLYPH_BITS-1:0] r_glyph;
    logic [tmgr_pkg::X_W-1:0]        r_x0;
    logic [tmgr_pkg::PAGE_W-1:0]     r_p0;
    logic [2:0]                      r_y_off;
    logic [2:0]                      r_dx;
    logic [1:0]                      r_ps;
    logic                            r_issue_done;

    // Pending write of the byte read in the cycle before
    logic                         r_wr_pend;
    logic [tmgr_pkg::ADDR_W-1:0]  r_wr_addr;
    logic [7:0]                   r_wr_mask;
    logic [tmgr_pkg::ADDR_W-1:0]  r_rd_addr;

    // Result registers
    logic [7:0] r_res_data;
    logic       r_res_acc;
    logic [3:0] r_res_col;
    logic [2:0] r_res_line;

    logic                         cmd_fire;
    logic                         put_ok;
    logic [5:0]                   y0;
    logic [4:0]                   col_inc;
    logic [tmgr_pkg::ADDR_W-1:0]  draw_addr;
    logic                         draw_last;
    tmgr_pkg::t_mask_req          mask_req;
    logic [7:0]                   mask;
    tmgr_pkg::t_mem_wr            mem_wr;
    logic                         rd_en;
    logic [tmgr_pkg::ADDR_W-1:0]  rd_addr;
    logic [7:0]                   rd_data;

    assign cmd_fire = i_cmd.valid && i_cmd.ready;

    // Put is taken unless terminator, screen full, or leading space
    assign put_ok = (i_cmd.char_code != tmgr_pkg::CH_NUL)
                 && (r_line < 3'(tmgr_pkg::TEXT_LINES))
                 && !((i_cmd.char_code == tmgr_pkg::CH_SPACE) && (r_col == 4'd0));

    // Glyph origin row: line*14 + 5
    assign y0 = 6'({r_line[1:0], 4'b0000}) - 6'({r_line[1:0], 1'b0})
              + 6'(tmgr_pkg::ORIGIN_Y);
    assign col_inc = {1'b0, r_col} + 5'd1;

    // Current byte of the draw sweep
    assign draw_addr = {r_p0 + tmgr_pkg::PAGE_W'(r_ps), r_x0 + tmgr_pkg::X_W'(r_dx)};
    assign draw_last = (r_dx == 3'(tmgr_pkg::BYTE_COLS - 1))
                    && (r_ps == 2'(tmgr_pkg::PAGE_SPAN - 1));

    assign mask_req = '{glyph: r_glyph, dot_col: r_dx[2:1], y_off: r_y_off,
                        page_sel: r_ps};

    tmgr_glyph_mask u_mask (
        .i_req  (mask_req),
        .o_mask (mask)
    );

    // Memory port selection
    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_wr = '{en: 1'b1, addr: r_clr_addr, data: 8'h00};
        end else begin
            mem_wr = '{en: r_wr_pend, addr: r_wr_addr, data: rd_data | r_wr_mask};
        end
        rd_en   = ((r_state == ST_PUT) && !r_issue_done) || (r_state == ST_RD);
        rd_addr = (r_state == ST_PUT) ? draw_addr : r_rd_addr;
    end

    tmgr_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_clr_reply  <= 1'b0;
            r_col        <= '0;
            r_line       <= '0;
            r_dx         <= '0;
            r_ps         <= '0;
            r_issue_done <= 1'b0;
            r_wr_pend    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == tmgr_pkg::ADDR_W'(tmgr_pkg::STORE_BYTES - 1)) begin
                        r_state <= r_clr_reply ? ST_RESP : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd_fire) begin
                        r_res_data <= 8'h00;
                        r_res_acc  <= 1'b0;
                        r_res_col  <= r_col;
                        r_res_line <= r_line;
                        r_rd_addr  <= i_cmd.read_address;
                        unique case (i_cmd.func)
                            tmgr_pkg::FN_CLEAR: begin
                                r_col       <= '0;
                                r_line      <= '0;
                                r_res_col   <= '0;
                                r_res_line  <= '0;
                                r_clr_addr  <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= ST_CLEAR;
                            end
                            tmgr_pkg::FN_PUT: begin
                                if (put_ok) begin
                                    r_glyph <= tmgr_pkg::glyph_bits(
                                                   tmgr_pkg::map_glyph(i_cmd.char_code));
                                    r_x0    <= {r_col, 3'b001};
                                    r_p0    <= y0[5:3];
                                    r_y_off <= y0[2:0];
                                    r_dx    <= '0;
                                    r_ps    <= '0;
                                    r_issue_done <= 1'b0;
                                    r_res_acc    <= 1'b1;
                                    if (col_inc >= 5'(tmgr_pkg::TEXT_COLUMNS)) begin
                                        r_col      <= '0;
                                        r_line     <= r_line + 3'd1;
                                        r_res_col  <= '0;
                                        r_res_line <= r_line + 3'd1;
                                    end else begin
                                        r_col     <= col_inc[3:0];
                                        r_res_col <= col_inc[3:0];
                                    end
                                    r_state <= ST_PUT;
                                end else begin
                                    r_state <= ST_RESP;
                                end
                            end
                            tmgr_pkg::FN_READ: begin
                                r_state <= ST_RD;
                            end
                            default: begin
                                r_state <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_PUT: begin
                    // One read issued per cycle; the previous byte is written back
                    if (!r_issue_done) begin
                        r_wr_pend <= 1'b1;
                        r_wr_addr <= draw_addr;
                        r_wr_mask <= mask;
                        if (draw_last) begin
                            r_issue_done <= 1'b1;
                        end else if (r_ps == 2'(tmgr_pkg::PAGE_SPAN - 1)) begin
                            r_ps <= '0;
                            r_dx <= r_dx + 3'd1;
                        end else begin
                            r_ps <= r_ps + 2'd1;
                        end
                    end else begin
                        r_wr_pend <= 1'b0;
                        r_state   <= ST_RESP;
                    end
                end
                ST_RD: begin
                    r_state <= ST_RD_WAIT;
                end
                ST_RD_WAIT: begin
                    r_res_data <= rd_data;
                    r_state    <= ST_RESP;
                end
                ST_RESP: begin
                    r_clr_reply <= 1'b0;
                    if (o_res.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready         = (r_state == ST_IDLE);
    assign o_res.valid         = (r_state == ST_RESP);
    assign o_res.read_data     = r_res_data;
    assign o_res.accepted      = r_res_acc;
    assign o_res.cursor_column = r_res_col;
    assign o_res.cursor_line   = r_res_line;

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for text_mode_glyph_renderer.
// Keeps a shadow framebuffer and cursor and predicts every result item.
// Depends on tmgr_pkg, tmgr_in_if, tmgr_out_if and the renderer RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] FN_UNUSED = 2'd3;

    // Cell geometry not exported by the package
    localparam int CELL_W   = 8;
    localparam int ORIGIN_X = 1;

    // Font indexes of the punctuation glyphs
    localparam int FONT_PERIOD   = 37;
    localparam int FONT_COMMA    = 38;
    localparam int FONT_BANG     = 39;
    localparam int FONT_QUESTION = 40;
    localparam int FONT_QUOTE    = 41;
    localparam int FONT_DASH     = 42;
    localparam int FONT_COLON    = 43;

    typedef struct packed {
        logic [7:0] read_data;
        logic       accepted;
        logic [3:0] cursor_column;
        logic [2:0] cursor_line;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    tmgr_in_if  cmd_if ();
    tmgr_out_if res_if ();

    text_mode_glyph_renderer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Shadow copy of the renderer state
    logic [7:0] shadow_fb [tmgr_pkg::STORE_BYTES];
    int         shadow_col;
    int         shadow_line;

    t_report expected_reports [$];

    int  mismatch_count;
    int  items_sent;
    int  results_checked;
    int  n_clear, n_put, n_drawn, n_read, n_unused;
    bit  quiet_tail;
    int  stall_left;

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Time limit
    initial begin
        #2000000;
        $display("Timeout at %0t with %0d results outstanding", $time, expected_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Character byte to font index, lowercase folded to uppercase
    function automatic int font_index(logic [7:0] ch);
        logic [7:0] c;
        c = ch;
        if (c >= "a" && c <= "z")
            c = c - 8'd32;
        if (c >= "A" && c <= "Z")
            return int'(c) - int'("A");
        if (c >= "0" && c <= "9")
            return int'(tmgr_pkg::DIGIT_BASE) + int'(c) - int'("0");
        case (c)
            ".":     return FONT_PERIOD;
            ",":     return FONT_COMMA;
            "!":     return FONT_BANG;
            "?":     return FONT_QUESTION;
            "'":     return FONT_QUOTE;
            "-":     return FONT_DASH;
            ":":     return FONT_COLON;
            default: return int'(tmgr_pkg::BLANK_GLYPH);
        endcase
    endfunction

    // Font as five decimal digits per glyph, one per row, top row first;
    // digit bit 2 is the left dot
    function automatic logic [14:0] font_dots(int idx);
        int rows;
        int div;
        logic [14:0] dots;
        case (idx)
            0:  rows = 25755;  1:  rows = 65656;  2:  rows = 34443;  3:  rows = 65556;
            4:  rows = 74647;  5:  rows = 74644;  6:  rows = 34553;  7:  rows = 55755;
            8:  rows = 72227;  9:  rows = 11152;  10: rows = 56465;  11: rows = 44447;
            12: rows = 57755;  13: rows = 65555;  14: rows = 25552;  15: rows = 65644;
            16: rows = 25521;  17: rows = 65665;  18: rows = 34216;  19: rows = 72222;
            20: rows = 55557;  21: rows = 55552;  22: rows = 55775;  23: rows = 55255;
            24: rows = 55222;  25: rows = 71247;
            26: rows = 75557;  27: rows = 26227;  28: rows = 61247;  29: rows = 61216;
            30: rows = 55711;  31: rows = 74616;  32: rows = 34652;  33: rows = 71222;
            34: rows = 75757;  35: rows = 25316;
            FONT_PERIOD:   rows = 2;
            FONT_COMMA:    rows = 24;
            FONT_BANG:     rows = 22202;
            FONT_QUESTION: rows = 61202;
            FONT_QUOTE:    rows = 22000;
            FONT_DASH:     rows = 700;
            FONT_COLON:    rows = 2020;
            default:       rows = 0;
        endcase
        div = 10000;
        for (int r = 0; r < 5; r++) begin
            dots[14 - 3 * r -: 3] = 3'((rows / div) % 10);
            div = div / 10;
        end
        return dots;
    endfunction

    // Apply one command to the shadow state and return the report it causes
    function automatic t_report apply_command(logic [1:0] fn, logic [7:0] ch,
                                              logic [9:0] addr);
        t_report    rep;
        logic [14:0] dots;
        int         x0, y0, px, py;
        rep = '0;
        case (fn)
            tmgr_pkg::FN_CLEAR: begin
                foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
                shadow_col  = 0;
                shadow_line = 0;
                n_clear++;
            end
            tmgr_pkg::FN_PUT: begin
                n_put++;
                if (ch != tmgr_pkg::CH_NUL && shadow_line < tmgr_pkg::TEXT_LINES &&
                    !(ch == tmgr_pkg::CH_SPACE && shadow_col == 0)) begin
                    dots = font_dots(font_index(ch));
                    x0   = shadow_col * CELL_W + ORIGIN_X;
                    y0   = shadow_line * tmgr_pkg::CELL_H + tmgr_pkg::ORIGIN_Y;
                    for (int r = 0; r < 5; r++)
                        for (int c = 0; c < 3; c++)
                            if (dots[14 - (r * 3 + c)])
                                for (int dy = 0; dy < 2; dy++)
                                    for (int dx = 0; dx < 2; dx++) begin
                                        px = x0 + 2 * c + dx;
                                        py = y0 + 2 * r + dy;
                                        if (px < tmgr_pkg::SCREEN_WIDTH &&
                                            py < tmgr_pkg::SCREEN_HEIGHT)
                                            shadow_fb[px + (py / 8) * tmgr_pkg::SCREEN_WIDTH]
                                                     [py % 8] = 1'b1;
                                    end
                    shadow_col++;
                    if (shadow_col >= tmgr_pkg::TEXT_COLUMNS) begin
                        shadow_col = 0;
                        shadow_line++;
                    end
                    rep.accepted = 1'b1;
                    n_drawn++;
                end
            end
            tmgr_pkg::FN_READ: begin
                rep.read_data = shadow_fb[addr];
                n_read++;
            end
            default: n_unused++;
        endcase
        rep.cursor_column = 4'(shadow_col);
        rep.cursor_line   = 3'(shadow_line);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and comparison
    // ------------------------------------------------------------------

    task automatic compare_field(string fname, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_checked++;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result: data %0d acc %0d col %0d line %0d",
                         $time, res_if.read_data, res_if.accepted,
                         res_if.cursor_column, res_if.cursor_line);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                compare_field("read_data", want.read_data, res_if.read_data);
                compare_field("accepted", 8'(want.accepted), 8'(res_if.accepted));
                compare_field("cursor_column", 8'(want.cursor_column),
                              8'(res_if.cursor_column));
                compare_field("cursor_line", 8'(want.cursor_line), 8'(res_if.cursor_line));
            end
        end
        // Stall in random bursts, none in the tail
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (quiet_tail) begin
            res_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 9) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 12);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Drive one command item and wait for it to be taken; valid stays high
    task automatic send_cmd(logic [1:0] fn, logic [7:0] ch, logic [9:0] addr);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.func         <= fn;
        cmd_if.char_code    <= ch;
        cmd_if.read_address <= addr;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        expected_reports.push_back(apply_command(fn, ch, addr));
        items_sent++;
    endtask

    // Stop sending until every outstanding result has come back
    task automatic hold_until_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_text_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) return 8'($urandom_range(65, 90));
        if (sel < 55) return 8'($urandom_range(97, 122));
        if (sel < 70) return 8'($urandom_range(48, 57));
        if (sel < 82) begin
            case ($urandom_range(0, 6))
                0:       return ".";
                1:       return ",";
                2:       return "!";
                3:       return "?";
                4:       return "'";
                5:       return "-";
                default: return ":";
            endcase
        end
        if (sel < 88) return tmgr_pkg::CH_SPACE;
        if (sel < 90) return tmgr_pkg::CH_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    // Half the reads land in a glyph's byte columns on any page, the rest anywhere
    function automatic logic [9:0] pick_read_address();
        int x;
        if ($urandom_range(0, 1) == 0)
            return 10'($urandom_range(0, tmgr_pkg::STORE_BYTES - 1));
        x = $urandom_range(0, tmgr_pkg::TEXT_COLUMNS - 1) * CELL_W + ORIGIN_X
          + $urandom_range(0, 5);
        return 10'(x + $urandom_range(0, 7) * tmgr_pkg::SCREEN_WIDTH);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every function code and the skip cases
    task automatic test_directed();
        send_cmd(tmgr_pkg::FN_READ, 8'hFF, 10'd0);
        send_cmd(FN_UNUSED, 8'h5A, 10'h3FF);
        send_cmd(tmgr_pkg::FN_PUT, tmgr_pkg::CH_NUL, 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, tmgr_pkg::CH_SPACE, 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "A", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "z", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "0", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "9", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, ".", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, ",", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "!", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "?", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "'", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "-", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, ":", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, tmgr_pkg::CH_SPACE, 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, 8'hFF, 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, 8'h80, 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "@", 10'd0);
        send_cmd(tmgr_pkg::FN_PUT, "[", 10'd0);
        send_cmd(tmgr_pkg::FN_READ, 8'h00, 10'd1);
        send_cmd(tmgr_pkg::FN_READ, 8'h00, 10'd130);
        send_cmd(tmgr_pkg::FN_READ, 8'h00, 10'h3FF);
        send_cmd(tmgr_pkg::FN_CLEAR, 8'h00, 10'd0);
        send_cmd(tmgr_pkg::FN_READ, 8'h00, 10'd1);
    endtask

    // Fill all text lines, then show that further puts are ignored
    task automatic test_fill_screen();
        send_cmd(tmgr_pkg::FN_CLEAR, 8'h00, 10'd0);
        while (shadow_line < tmgr_pkg::TEXT_LINES) begin
            if ($urandom_range(0, 7) == 0)
                send_cmd(tmgr_pkg::FN_READ, 8'($urandom), pick_read_address());
            else
                send_cmd(tmgr_pkg::FN_PUT, pick_text_char(), 10'($urandom));
        end
        repeat (6) send_cmd(tmgr_pkg::FN_PUT, pick_text_char(), 10'($urandom));
        repeat (6) send_cmd(tmgr_pkg::FN_READ, 8'($urandom), pick_read_address());
    endtask

    // Text runs with random content, reads of the result and occasional clears
    task automatic test_text_runs(int budget);
        int stop_at;
        int run_len;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0)
                send_cmd(tmgr_pkg::FN_CLEAR, 8'($urandom), 10'($urandom));
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 20);
            for (int i = 0; i < run_len; i++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: send_cmd(tmgr_pkg::FN_READ, 8'($urandom),
                                         pick_read_address());
                    4:          send_cmd(FN_UNUSED, 8'($urandom), 10'($urandom));
                    default:    send_cmd(tmgr_pkg::FN_PUT, pick_text_char(),
                                         10'($urandom));
                endcase
            end
        end
    endtask

    // Unstructured commands over the whole input space
    task automatic test_noise(int count);
        int sel;
        logic [1:0] fn;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            fn  = (sel < 5)  ? tmgr_pkg::FN_CLEAR :
                  (sel < 50) ? tmgr_pkg::FN_PUT   :
                  (sel < 85) ? tmgr_pkg::FN_READ  : FN_UNUSED;
            send_cmd(fn, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        mismatch_count  = 0;
        items_sent      = 0;
        results_checked = 0;
        n_clear  = 0;
        n_put    = 0;
        n_drawn  = 0;
        n_read   = 0;
        n_unused = 0;
        quiet_tail = 1'b0;
        stall_left = 0;
        shadow_col  = 0;
        shadow_line = 0;
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

        i_rst_n             <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.func         <= tmgr_pkg::FN_CLEAR;
        cmd_if.char_code    <= tmgr_pkg::CH_NUL;
        cmd_if.read_address <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_screen();
        test_text_runs(120);
        hold_until_drained();
        test_noise(50);
        test_text_runs(60);
        hold_until_drained();
        quiet_tail = 1'b1;
        test_text_runs(30);

        // Wait for the last results, then a short settle
        hold_until_drained();
        repeat (30) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_reports.size());
            mismatch_count++;
        end

        $display("Sent %0d items: %0d clears, %0d puts (%0d drawn), %0d reads, %0d unused code",
                 items_sent, n_clear, n_put, n_drawn, n_read, n_unused);
        $display("Checked %0d result items, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
